>>> rtl/core/dqvs_pkg.sv
// ----------------------------------------------------------------------------
// dqvs_pkg
// Shared codes, defaults and the result beat type of the searchable deque.
// ----------------------------------------------------------------------------
package dqvs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes carried by an input beat.
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_CONTAINS   = 3'd4;
  localparam logic [2:0] OP_REMOVE     = 3'd5;

  // Error codes reported with every result beat.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_EMPTY     = 2'd2;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_total;
    logic               is_empty;
    logic               found;
    logic [1:0]         error_code;
  } dqvs_result_t;

endpackage

>>> rtl/core/dqvs_ram.sv
// ----------------------------------------------------------------------------
// dqvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dqvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/dqvs_engine.sv
// ----------------------------------------------------------------------------
// dqvs_engine
// Sequencer of the deque: ring pointers, search, gap closing and end refresh.
// ----------------------------------------------------------------------------
module dqvs_engine #(
  parameter int DEPTH      = dqvs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dqvs_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_operation,
  input  logic signed [31:0]         in_item_value,
  input  logic                       out_free,
  output logic                       done,
  output dqvs_pkg::dqvs_result_t     result,
  output logic                       ram_wr_en,
  output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
  output logic [VALUE_BITS-1:0]      ram_wr_data,
  output logic                       ram_rd_en,
  output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
  input  logic [VALUE_BITS-1:0]      ram_rd_data
);

  import dqvs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_SH_RD = 4'd3;
  localparam logic [3:0] S_SH_WR = 4'd4;
  localparam logic [3:0] S_RD_F  = 4'd5;
  localparam logic [3:0] S_RD_B  = 4'd6;
  localparam logic [3:0] S_CAP_B = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  found_r, found_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [31:0]           front_r, front_nxt;
  logic [31:0]           back_r, back_nxt;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [VALUE_BITS-1:0] in_val;
  logic [AW-1:0]         head_dec;
  logic [CW+4:0]         count_wide;

  // Physical slot of logical position i, counted from the head of the ring.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [VALUE_BITS-1:0] d);
    logic signed [EW-1:0] w;
    w = EW'(signed'(d));
    return w[31:0];
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_val   = VALUE_BITS'(in_item_value);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    found_nxt   = found_r;
    err_nxt     = err_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = head_r;
    ram_wr_data = in_val;
    ram_rd_en   = 1'b0;
    ram_rd_addr = head_r;
    done        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          val_nxt   = in_val;
          found_nxt = 1'b0;
          err_nxt   = ERR_NONE;
          idx_nxt   = '0;
          case (in_operation)
            OP_PUSH_FRONT: begin
              if (full) begin
                err_nxt   = ERR_FULL;
                state_nxt = S_FIN;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_dec;
                head_nxt    = head_dec;
                count_nxt   = count_r + 1'b1;
                state_nxt   = S_RD_F;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                err_nxt   = ERR_FULL;
                state_nxt = S_FIN;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_r, count_r);
                count_nxt   = count_r + 1'b1;
                state_nxt   = S_RD_F;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                err_nxt   = ERR_EMPTY;
                state_nxt = S_FIN;
              end else begin
                head_nxt  = phys(head_r, CW'(1));
                count_nxt = count_r - 1'b1;
                state_nxt = S_RD_F;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                err_nxt   = ERR_EMPTY;
                state_nxt = S_FIN;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_RD_F;
              end
            end
            OP_CONTAINS, OP_REMOVE: begin
              state_nxt = S_SRCH;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (idx_r == count_r) begin
          if (op_r == OP_REMOVE) begin
            err_nxt = ERR_NOT_FOUND;
          end
          state_nxt = S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = phys(head_r, idx_r);
          state_nxt   = S_CMP;
        end
      end

      S_CMP: begin
        if (ram_rd_data == val_r) begin
          found_nxt = 1'b1;
          state_nxt = (op_r == OP_REMOVE) ? S_SH_RD : S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRCH;
        end
      end

      S_SH_RD: begin
        if ((idx_r + 1'b1) >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RD_F;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = phys(head_r, idx_r + 1'b1);
          state_nxt   = S_SH_WR;
        end
      end

      S_SH_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = phys(head_r, idx_r);
        ram_wr_data = ram_rd_data;
        idx_nxt     = idx_r + 1'b1;
        state_nxt   = S_SH_RD;
      end

      S_RD_F: begin
        if (empty) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = head_r;
          state_nxt   = S_RD_B;
        end
      end

      S_RD_B: begin
        front_nxt   = to_out(ram_rd_data);
        ram_rd_en   = 1'b1;
        ram_rd_addr = phys(head_r, count_r - 1'b1);
        state_nxt   = S_CAP_B;
      end

      S_CAP_B: begin
        back_nxt  = to_out(ram_rd_data);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_wide         = (CW+5)'(count_r);
  assign result.front_value = front_r;
  assign result.back_value  = back_r;
  assign result.entry_total = count_wide[4:0];
  assign result.is_empty    = empty;
  assign result.found       = found_r;
  assign result.error_code  = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      found_r <= 1'b0;
      err_r   <= ERR_NONE;
      front_r <= '0;
      back_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      err_r   <= err_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    op_r  <= op_nxt;
    val_r <= val_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)))
    else $error("read and write of the same slot in one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + 1'b1) || (count_r + 1'b1 == $past(count_r))))
    else $error("entry count moved by more than one");

endmodule

>>> rtl/core/deque_with_value_search.sv
// ----------------------------------------------------------------------------
// deque_with_value_search
// Bounded double-ended queue of signed words with value search and removal.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ------------------------------------
//  in_      input      in_valid/in_stall   in_operation, in_item_value
//  out_     output     out_valid/out_stall out_front_value, out_back_value,
//                                          out_entry_total, out_is_empty,
//                                          out_found, out_error_code
//
// Each input beat yields exactly one output beat. A push writes its entry to
// the RAM, a pop only moves the ring pointers; both then refresh the cached
// front and back values with two reads through the single read port of the
// entry RAM, unless the deque is left empty. Contains reads and compares the
// entries in turn from the front and stops at a match; on a match, remove
// then moves each later entry down a slot to close the gap and does the
// refresh reads. Full and empty errors and undefined codes go straight to
// the finish state. Reset is synchronous and clears the ring pointers, the
// count and the output valid flag; RAM contents are never read before being
// written. One beat is worked at a time; a finished result waits in the
// output register while out_stall is high, and the next beat is taken as soon as the engine has handed its result over.
module deque_with_value_search #(
  parameter int DEPTH      = dqvs_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dqvs_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value,
  output logic [4:0]         out_entry_total,
  output logic               out_is_empty,
  output logic               out_found,
  output logic [1:0]         out_error_code
);

  import dqvs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [VALUE_BITS-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [VALUE_BITS-1:0] ram_rd_data;

  logic         done;
  logic         out_free;
  dqvs_result_t eng_result;
  dqvs_result_t res_r;
  logic         out_valid_r;

  // The output register is free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  dqvs_engine #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_item_value (in_item_value),
    .out_free      (out_free),
    .done          (done),
    .result        (eng_result),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data)
  );

  // Ring storage of the entries; the engine keeps head and count.
  dqvs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Output register: the engine only finishes when it can load here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= eng_result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = res_r.front_value;
  assign out_back_value  = res_r.back_value;
  assign out_entry_total = res_r.entry_total;
  assign out_is_empty    = res_r.is_empty;
  assign out_found       = res_r.found;
  assign out_error_code  = res_r.error_code;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the searchable deque. A short table of directed
// beats covers the empty and full corners, the extreme words and every
// operation code. Random traffic follows in fill, drain and search phases.
// Each result beat is checked against an in-bench shadow of the deque or a hand-written result.
// ----------------------------------------------------------------------------
module testbench;
  import dqvs_pkg::*;

  localparam int QUEUE_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 400000;

  // The two operation codes that the block must ignore.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [31:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_ALT  = 32'sh5555_5555;
  localparam logic signed [31:0] WORD_MISS = 32'sh1234_5678;

  // Traffic phases of the random part.
  localparam int PHASE_FILL   = 0;
  localparam int PHASE_DRAIN  = 1;
  localparam int PHASE_SEARCH = 2;

  // One row of the directed table. A row with typed_in set carries its
  // result written out by hand; other rows are checked against the shadow.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         copies;
    logic               typed_in;
    dqvs_result_t       typed_result;
  } stim_row_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [2:0]         in_operation  = OP_PUSH_BACK;
  logic signed [31:0] in_item_value = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [31:0] out_front_value;
  logic signed [31:0] out_back_value;
  logic [4:0]         out_entry_total;
  logic               out_is_empty;
  logic               out_found;
  logic [1:0]         out_error_code;

  // Shadow copy of the deque contents, front at index 0.
  logic signed [31:0] held_words[$];
  // Queue views still owed by the block, oldest first.
  dqvs_result_t       pending_views[$];
  stim_row_t          directed_rows[$];
  logic signed [31:0] value_pool[8];

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  beats_sent     = 0;
  int  beats_checked  = 0;
  int  full_hits      = 0;
  int  empty_hits     = 0;
  int  remove_hits    = 0;
  int  remove_misses  = 0;
  int  contains_hits  = 0;
  bit  quiet_tail     = 1'b0;
  bit  gap_mode       = 1'b0;

  deque_with_value_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_total (out_entry_total),
    .out_is_empty    (out_is_empty),
    .out_found       (out_found),
    .out_error_code  (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run is a remove that scans and compacts the
  // whole store on every beat, with the longest stall and gap around it; even
  // then the whole bench ends far below this limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d views still owed", cycle_count,
               pending_views.size());
      $display("deque_with_value_search test failed");
      $finish;
    end
  end

  // Shadow of the block. Applies one operation to held_words and returns the
  // view of the queue that the block should report afterwards.
  function automatic dqvs_result_t deque_step(input logic [2:0] op,
                                              input logic signed [31:0] value);
    dqvs_result_t view;
    int           hit_at;
    view   = '0;
    hit_at = -1;
    // Contains and remove both act on the match nearest the front.
    foreach (held_words[i]) begin
      if (hit_at < 0 && held_words[i] == value) hit_at = i;
    end
    case (op)
      OP_PUSH_FRONT: begin
        if (held_words.size() >= QUEUE_DEPTH) view.error_code = ERR_FULL;
        else held_words.push_front(value);
      end
      OP_PUSH_BACK: begin
        if (held_words.size() >= QUEUE_DEPTH) view.error_code = ERR_FULL;
        else held_words.push_back(value);
      end
      OP_POP_FRONT: begin
        if (held_words.size() == 0) view.error_code = ERR_EMPTY;
        else void'(held_words.pop_front());
      end
      OP_POP_BACK: begin
        if (held_words.size() == 0) view.error_code = ERR_EMPTY;
        else void'(held_words.pop_back());
      end
      OP_CONTAINS: begin
        view.found = (hit_at >= 0);
      end
      OP_REMOVE: begin
        // A removal closes the gap, so deleting from the shadow queue keeps
        // the remaining order just as the block's compaction does.
        if (hit_at >= 0) begin
          view.found = 1'b1;
          held_words.delete(hit_at);
        end else begin
          view.error_code = ERR_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (held_words.size() > 0) begin
      view.front_value = held_words[0];
      view.back_value  = held_words[held_words.size() - 1];
    end
    view.entry_total = 5'(held_words.size());
    view.is_empty    = (held_words.size() == 0);
    return view;
  endfunction

  function automatic string view_text(input dqvs_result_t v);
    return $sformatf("front %0d back %0d total %0d empty %0b found %0b err %0d",
                     v.front_value, v.back_value, v.entry_total, v.is_empty,
                     v.found, v.error_code);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic signed [31:0] value,
                                  input int copies);
    stim_row_t row;
    row        = '0;
    row.op     = op;
    row.value  = value;
    row.copies = 8'(copies);
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked_row(input logic [2:0] op,
                                          input logic signed [31:0] value,
                                          input logic signed [31:0] front,
                                          input logic signed [31:0] back,
                                          input int total, input bit empty,
                                          input bit hit, input logic [1:0] err);
    stim_row_t row;
    row                          = '0;
    row.op                       = op;
    row.value                    = value;
    row.copies                   = 8'd1;
    row.typed_in                 = 1'b1;
    row.typed_result.front_value = front;
    row.typed_result.back_value  = back;
    row.typed_result.entry_total = 5'(total);
    row.typed_result.is_empty    = empty;
    row.typed_result.found       = hit;
    row.typed_result.error_code  = err;
    directed_rows.push_back(row);
  endfunction

  // Mostly values that are already held or that come back often, so that
  // contains and remove hit as well as miss; the rest is arbitrary.
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30 && held_words.size() > 0)
      return held_words[$urandom_range(0, held_words.size() - 1)];
    if (roll < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_operation(input int phase);
    int unsigned roll;
    int          push_cut, pop_cut, find_cut;
    roll = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL:  begin push_cut = 70; pop_cut = 80; find_cut = 90; end
      PHASE_DRAIN: begin push_cut = 15; pop_cut = 70; find_cut = 85; end
      default:     begin push_cut = 30; pop_cut = 45; find_cut = 70; end
    endcase
    if (roll < push_cut) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    if (roll < pop_cut)  return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    if (roll < find_cut) return OP_CONTAINS;
    return OP_REMOVE;
  endfunction

  // Presents one beat, holds it until it is taken, then books the view that
  // the block owes for it. in_valid stays high so back-to-back beats need no
  // second assignment in the same step.
  task automatic send_beat(input logic [2:0] op, input logic signed [31:0] value,
                           input bit typed_in, input dqvs_result_t typed_result);
    dqvs_result_t predicted;
    if (!quiet_tail && gap_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_item_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = deque_step(op, value);
    pending_views.push_back(typed_in ? typed_result : predicted);
    beats_sent++;
    if (predicted.error_code == ERR_FULL)  full_hits++;
    if (predicted.error_code == ERR_EMPTY) empty_hits++;
    if (op == OP_REMOVE && predicted.found)  remove_hits++;
    if (op == OP_REMOVE && !predicted.found) remove_misses++;
    if (op == OP_CONTAINS && predicted.found) contains_hits++;
  endtask

  // Result side. A beat is taken at an edge where out_valid is high and our
  // own stall was low; both are read before this edge's updates land.
  always @(posedge clk) begin
    dqvs_result_t got, want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.front_value = out_front_value;
      got.back_value  = out_back_value;
      got.entry_total = out_entry_total;
      got.is_empty    = out_is_empty;
      got.found       = out_found;
      got.error_code  = out_error_code;
      if (pending_views.size() == 0) begin
        note_mismatch({"result beat with nothing owed: ", view_text(got)});
      end else begin
        want = pending_views.pop_front();
        beats_checked++;
        if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
            got.entry_total !== want.entry_total || got.is_empty !== want.is_empty ||
            got.found !== want.found || got.error_code !== want.error_code)
          note_mismatch({"\n  expected ", view_text(want), "\n  actual   ", view_text(got)});
      end
    end
  end

  // Receiver back-pressure: runs of free cycles, now and then a long one,
  // broken by stall bursts. None once the tail begins.
  initial begin
    int unsigned run_len;
    forever begin
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                             : $urandom_range(1, 30);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      if (!quiet_tail) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin
    int          counted;
    int          segment_end;
    int          phase;
    logic [2:0]  op;
    dqvs_result_t no_view;

    no_view = '0;
    value_pool[0] = WORD_MAX;
    value_pool[1] = WORD_MIN;
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    value_pool[5] = $urandom();
    value_pool[6] = $urandom();
    value_pool[7] = $urandom();

    // Directed table. The empty queue is probed first: both pops, a remove
    // and a contains that find nothing, and an undefined code. Then the
    // extreme words go in at both ends, the store is filled with copies of one
    // word at the back and a -1 at the front, so that a push at either end hits
    // the full limit, and the searches pick the front-most copy out of the middle.
    add_checked_row(OP_POP_FRONT,  '0,        '0, '0, 0, 1, 0, ERR_EMPTY);
    add_checked_row(OP_POP_BACK,   -1,        '0, '0, 0, 1, 0, ERR_EMPTY);
    add_checked_row(OP_REMOVE,     '0,        '0, '0, 0, 1, 0, ERR_NOT_FOUND);
    add_checked_row(OP_CONTAINS,   WORD_MIN,  '0, '0, 0, 1, 0, ERR_NONE);
    add_checked_row(OP_SPARE_6,    WORD_MAX,  '0, '0, 0, 1, 0, ERR_NONE);
    add_checked_row(OP_PUSH_BACK,  WORD_MAX,  WORD_MAX, WORD_MAX, 1, 0, 0, ERR_NONE);
    add_checked_row(OP_PUSH_FRONT, WORD_MIN,  WORD_MIN, WORD_MAX, 2, 0, 0, ERR_NONE);
    add_checked_row(OP_CONTAINS,   WORD_MIN,  WORD_MIN, WORD_MAX, 2, 0, 1, ERR_NONE);
    add_row(OP_PUSH_BACK,  WORD_ALT, QUEUE_DEPTH - 3);
    add_row(OP_PUSH_FRONT, -1, 1);
    add_checked_row(OP_PUSH_FRONT, '0,        -1, WORD_ALT, QUEUE_DEPTH, 0, 0, ERR_FULL);
    add_checked_row(OP_PUSH_BACK,  1,         -1, WORD_ALT, QUEUE_DEPTH, 0, 0, ERR_FULL);
    add_row(OP_REMOVE,     WORD_MAX, 1);
    add_row(OP_REMOVE,     WORD_ALT, 1);
    add_row(OP_CONTAINS,   WORD_ALT, 1);
    add_row(OP_REMOVE,     WORD_MISS, 1);
    add_row(OP_SPARE_7,    WORD_MISS, 1);
    add_row(OP_POP_FRONT,  '0, 1);
    add_row(OP_POP_BACK,   '0, 1);

    // Synchronous reset, held at the start and never raised again.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_mode = 1'b1;
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].copies; k++)
        send_beat(directed_rows[i].op, directed_rows[i].value,
                  directed_rows[i].typed_in, directed_rows[i].typed_result);
    end

    // Random part, in phases of 20 to 60 beats that lean toward filling,
    // draining or searching, so that both the full and empty limits are
    // reached again and again. Undefined codes are sprinkled in and do not
    // count toward the total.
    counted     = 0;
    segment_end = 0;
    phase       = PHASE_FILL;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= segment_end) begin
        phase       = $urandom_range(PHASE_FILL, PHASE_SEARCH);
        gap_mode    = ($urandom_range(0, 2) != 0);
        segment_end = counted + $urandom_range(20, 60);
      end
      quiet_tail = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
      if ($urandom_range(0, 49) == 0) begin
        op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end else begin
        op = pick_operation(phase);
        counted++;
      end
      send_beat(op, pick_value(), 1'b0, no_view);
    end
    in_valid <= 1'b0;

    // Wait for every owed view, then leave room for a stray extra beat.
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats, checked %0d results, %0d mismatches", beats_sent,
             beats_checked, mismatch_count);
    $display("full %0d, empty %0d, remove hit/miss %0d/%0d, contains hits %0d",
             full_hits, empty_hits, remove_hits, remove_misses, contains_hits);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("deque_with_value_search test passed");
    end else begin
      $display("deque_with_value_search test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dqvs_pkg.sv
rtl/core/dqvs_ram.sv
rtl/core/dqvs_engine.sv
rtl/core/deque_with_value_search.sv
dv/testbench.sv
